[src/flfa_pkg.sv]
// ----------------------------------------------------------------------------
// flfa_pkg - shared types and constants of the free-list fit allocator
// Table geometry, field widths, status codes and the structs that pass
// between the controller and the row of table cells.
// ----------------------------------------------------------------------------
package flfa_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = 16;
    localparam int SIZE_W      = 16;
    localparam int BYTES_W     = 21;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_ZERO  = 2'd3;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic POLICY_FIRST = 1'b0;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              free;
    } entry_t;

    // running best candidate handed from cell to cell during a scan
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } token_t;

    typedef struct packed {
        logic [SIZE_W-1:0] req;
        logic              policy;
        logic [CNT_W-1:0]  count;
    } search_t;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_ADD,
        UPD_ALLOC
    } upd_kind_t;

    typedef struct packed {
        upd_kind_t         kind;
        logic [IDX_W-1:0]  tgt;
        logic              split;
        logic [SIZE_W-1:0] req;
        entry_t            fresh;
    } upd_t;

endpackage

[src/free_list_fit_allocator.sv]
// ----------------------------------------------------------------------------
// free_list_fit_allocator - first-fit / best-fit free-list allocator
// Ordered region table held in a row of cells, with a controller that
// appends regions, scans for a fitting region and splits it on a grant.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: s_tuser is the command (add or allocate),
//   s_tdata carries region_start and byte_count. Each request gives exactly
//   one result on the m_ stream: status in m_tuser, granted address and the
//   running free-region count and free-byte total in m_tdata.
//   cfg_we/cfg_wdata write the fit policy (0 first fit, 1 best fit); write it
//   only while no request is in flight.
// Sequencing:
//   Adds and requests refused at once (zero size, add into a full table)
//   go from acceptance straight to the emit step, which loads the output
//   register and raises m_tvalid; the block then returns to idle.
//   An allocate walks the candidate token down the cell row one cell per
//   cycle, each cell registering it; then the decide step grants the region
//   and updates the table (the grant plus a shift that opens a slot for a
//   split remainder), and the emit step loads the result.
//   One request is processed at a time; s_tready is high while the block is
//   idle, even when an earlier result still waits on m_tready. If the output
//   register is occupied when a new result is ready, the block holds it.
// Reset: aresetn (sync, active low) empties the table, clears the free
//   counters and the output, and selects first fit.
// ----------------------------------------------------------------------------
module free_list_fit_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,      // fit_policy
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // [15:0] region_start, [31:16] byte_count
    input  logic        s_tuser,        // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,        // [15:0] granted_address,
                                        // [21:16] free_region_count,
                                        // [42:22] free_byte_total, rest zero
    output logic [1:0]  m_tuser         // [1:0] status
);

    localparam int N = flfa_pkg::MAX_ENTRIES;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_EMIT
    } state_t;

    state_t                          state_reg;
    logic                            policy_reg;
    logic [flfa_pkg::CNT_W-1:0]      entry_count_reg;
    logic [flfa_pkg::CNT_W-1:0]      free_entries_reg;
    logic [flfa_pkg::BYTES_W-1:0]    free_bytes_reg;
    logic [flfa_pkg::SIZE_W-1:0]     req_reg;
    logic [flfa_pkg::IDX_W-1:0]      scan_cnt_reg;
    logic [1:0]                      res_status_reg;
    logic [flfa_pkg::ADDR_W-1:0]     res_addr_reg;
    logic                            m_tvalid_reg;
    logic [47:0]                     m_tdata_reg;
    logic [1:0]                      m_tuser_reg;

    logic                            accept;
    logic                            in_cmd;
    logic [flfa_pkg::ADDR_W-1:0]     in_start;
    logic [flfa_pkg::SIZE_W-1:0]     in_count;
    logic                            table_full;
    logic [flfa_pkg::SIZE_W-1:0]     rem;
    logic                            add_ok;
    logic                            grant_ok;
    flfa_pkg::search_t               search;
    flfa_pkg::upd_t                  upd;
    flfa_pkg::token_t                tok_w   [0:N];
    flfa_pkg::entry_t                entry_w [0:N-1];
    flfa_pkg::token_t                tok_last;

    assign accept     = s_tvalid && s_tready;
    assign in_cmd     = s_tuser;
    assign in_start   = s_tdata[15:0];
    assign in_count   = s_tdata[31:16];
    assign table_full = entry_count_reg == flfa_pkg::CNT_W'(N);
    assign tok_last   = tok_w[N];
    assign rem        = tok_last.size - req_reg;

    assign add_ok   = accept && (in_cmd == flfa_pkg::CMD_ADD) &&
                      (in_count != '0) && !table_full;
    assign grant_ok = (state_reg == S_DECIDE) && tok_last.found &&
                      !((rem != '0) && table_full);

    assign search.req    = req_reg;
    assign search.policy = policy_reg;
    assign search.count  = entry_count_reg;

    always_comb begin
        upd.kind        = flfa_pkg::UPD_NONE;
        upd.tgt         = entry_count_reg[flfa_pkg::IDX_W-1:0];
        upd.split       = 1'b0;
        upd.req         = req_reg;
        upd.fresh.start = in_start;
        upd.fresh.size  = in_count;
        upd.fresh.free  = 1'b1;
        if (add_ok) begin
            upd.kind = flfa_pkg::UPD_ADD;
        end else if (grant_ok) begin
            upd.kind        = flfa_pkg::UPD_ALLOC;
            upd.tgt         = tok_last.idx;
            upd.split       = rem != '0;
            upd.fresh.start = tok_last.start + req_reg;
            upd.fresh.size  = rem;
        end
    end

    // the row starts from an empty candidate
    assign tok_w[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        flfa_pkg::entry_t left_entry;
        if (g == 0) begin : g_first
            assign left_entry = '0;
        end else begin : g_rest
            assign left_entry = entry_w[g-1];
        end
        flfa_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (flfa_pkg::IDX_W'(g)),
            .search     (search),
            .upd        (upd),
            .tok_in     (tok_w[g]),
            .tok_out    (tok_w[g+1]),
            .left_entry (left_entry),
            .entry      (entry_w[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            policy_reg       <= flfa_pkg::POLICY_FIRST;
            entry_count_reg  <= '0;
            free_entries_reg <= '0;
            free_bytes_reg   <= '0;
            scan_cnt_reg     <= '0;
            res_status_reg   <= flfa_pkg::STAT_OK;
            res_addr_reg     <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
            m_tuser_reg      <= flfa_pkg::STAT_OK;
        end else begin
            if (cfg_we) begin
                policy_reg <= cfg_wdata;
            end
            // in the emit step the output register is refilled instead
            if (m_tvalid_reg && m_tready && (state_reg != S_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        req_reg      <= in_count;
                        res_addr_reg <= '0;
                        scan_cnt_reg <= '0;
                        if (in_count == '0) begin
                            res_status_reg <= flfa_pkg::STAT_ZERO;
                            state_reg      <= S_EMIT;
                        end else if (in_cmd == flfa_pkg::CMD_ALLOC) begin
                            state_reg <= S_SCAN;
                        end else if (table_full) begin
                            res_status_reg <= flfa_pkg::STAT_FULL;
                            state_reg      <= S_EMIT;
                        end else begin
                            res_status_reg   <= flfa_pkg::STAT_OK;
                            entry_count_reg  <= entry_count_reg + 1'b1;
                            free_entries_reg <= free_entries_reg + 1'b1;
                            free_bytes_reg   <= free_bytes_reg +
                                                flfa_pkg::BYTES_W'(in_count);
                            state_reg        <= S_EMIT;
                        end
                    end
                end
                S_SCAN: begin
                    // the token moves one cell per cycle until it reaches the row end
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == flfa_pkg::IDX_W'(N - 1)) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    state_reg <= S_EMIT;
                    if (!tok_last.found) begin
                        res_status_reg <= flfa_pkg::STAT_NOFIT;
                    end else if (!grant_ok) begin
                        res_status_reg <= flfa_pkg::STAT_FULL;
                    end else begin
                        res_status_reg <= flfa_pkg::STAT_OK;
                        res_addr_reg   <= tok_last.start;
                        free_bytes_reg <= free_bytes_reg -
                                          flfa_pkg::BYTES_W'(req_reg);
                        if (rem != '0) begin
                            entry_count_reg <= entry_count_reg + 1'b1;
                        end else begin
                            free_entries_reg <= free_entries_reg - 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= {5'd0, free_bytes_reg, free_entries_reg,
                                         res_addr_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a free entry is always a table entry
    a_free_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        free_entries_reg <= entry_count_reg)
        else $error("free entry count exceeds table fill");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg <= flfa_pkg::CNT_W'(N))
        else $error("table fill beyond capacity");

    // the scan never picks a slot outside the filled table
    a_pick_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECIDE && tok_last.found) |->
            (flfa_pkg::CNT_W'(tok_last.idx) < entry_count_reg))
        else $error("chosen entry outside table");

    // a granted request always leaves the table one slot fuller or one free entry fewer
    a_grant_effect: assert property (@(posedge aclk) disable iff (!aresetn)
        grant_ok |=> (entry_count_reg == $past(entry_count_reg) + 1'b1) ||
                     (free_entries_reg == $past(free_entries_reg) - 1'b1))
        else $error("grant without table update");

endmodule

[src/flfa_cell.sv]
// ----------------------------------------------------------------------------
// flfa_cell - one table entry of the allocator
// Holds start, size and free mark of one region, folds itself into the
// best-candidate token on its way down the row, and takes part in appends,
// grants and the shift that opens a slot for a split remainder.
// ----------------------------------------------------------------------------
module flfa_cell (
    input  logic                         aclk,
    input  logic [flfa_pkg::IDX_W-1:0]   cell_idx,
    input  flfa_pkg::search_t            search,
    input  flfa_pkg::upd_t               upd,
    input  flfa_pkg::token_t             tok_in,
    output flfa_pkg::token_t             tok_out,
    input  flfa_pkg::entry_t             left_entry,
    output flfa_pkg::entry_t             entry
);

    flfa_pkg::entry_t entry_reg;
    flfa_pkg::entry_t entry_next;
    flfa_pkg::token_t tok_reg;
    flfa_pkg::token_t tok_next;

    logic                       in_table;
    logic                       fits;
    logic                       take;
    logic [flfa_pkg::IDX_W:0]   idx_ext;
    logic [flfa_pkg::IDX_W:0]   tgt_ext;

    assign idx_ext  = {1'b0, cell_idx};
    assign tgt_ext  = {1'b0, upd.tgt} + {{flfa_pkg::IDX_W{1'b0}}, 1'b1};
    assign in_table = flfa_pkg::CNT_W'(cell_idx) < search.count;
    assign fits     = in_table && entry_reg.free && (entry_reg.size >= search.req);
    // best fit replaces only on a strictly smaller size, so ties stay earliest
    assign take     = fits && (!tok_in.found ||
                      ((search.policy != flfa_pkg::POLICY_FIRST) &&
                       (entry_reg.size < tok_in.size)));

    always_comb begin
        if (take) begin
            tok_next.found = 1'b1;
            tok_next.idx   = cell_idx;
            tok_next.start = entry_reg.start;
            tok_next.size  = entry_reg.size;
        end else begin
            tok_next = tok_in;
        end
    end

    always_comb begin
        entry_next = entry_reg;
        case (upd.kind)
            flfa_pkg::UPD_ADD: begin
                if (cell_idx == upd.tgt) begin
                    entry_next = upd.fresh;
                end
            end
            flfa_pkg::UPD_ALLOC: begin
                if (cell_idx == upd.tgt) begin
                    entry_next.size = upd.req;
                    entry_next.free = 1'b0;
                end else if (upd.split && (idx_ext == tgt_ext)) begin
                    entry_next = upd.fresh;
                end else if (upd.split && (idx_ext > tgt_ext)) begin
                    entry_next = left_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        tok_reg   <= tok_next;
    end

    assign entry   = entry_reg;
    assign tok_out = tok_reg;

endmodule
